FILE: sv/scpe_pkg.sv
// ----------------------------------------------------------------------------
// scpe_pkg
// Shared types and constants of the sector cache policy engine: sizes, request
// and command codes, controller states and the controller/datapath buses.
// ----------------------------------------------------------------------------
package scpe_pkg;

    // Tag store geometry
    localparam int CACHE_SLOTS = 64;
    localparam int SLOT_W      = $clog2(CACHE_SLOTS);
    localparam int CNT_W       = $clog2(CACHE_SLOTS + 1);
    localparam int SLOT_PORT_W = 6;
    localparam int SECTOR_W    = 32;

    // Reserved tag value that never matches in a lookup
    localparam logic [SECTOR_W-1:0] EMPTY_TAG = '1;

    // Configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // Request modes
    typedef enum logic [1:0] {
        MODE_READ  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_FLUSH = 2'd2,
        MODE_INVAL = 2'd3
    } t_mode;

    // Data-movement commands
    typedef enum logic [2:0] {
        CMD_FROM_BUFFER   = 3'd0,
        CMD_FROM_SLOT     = 3'd1,
        CMD_DEVICE_READ   = 3'd2,
        CMD_WRITE_THROUGH = 3'd3,
        CMD_FLUSH_THROUGH = 3'd4,
        CMD_LATCH         = 3'd5,
        CMD_NONE          = 3'd6
    } t_cmd_code;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_PRE,
        S_MAIN,
        S_SCAN,
        S_EMIT,
        S_RD_BUF,
        S_NONE,
        S_LATCH
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic      load_req;
        logic      start_scan;
        logic      key_buf;
        t_cmd_code cmd_hit;
        t_cmd_code cmd_miss;
        logic      last;
        logic      scan_run;
        logic      emit_search;
        logic      emit_direct;
        t_cmd_code direct_code;
        logic      clear_bvalid;
        logic      latch_buf;
        logic      clear_tags;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        t_mode mode;
        logic  bvalid;
        logic  buf_eq_req;
        logic  scan_done;
        logic  out_free;
    } t_dp_stat;

endpackage

FILE: sv/scpe_ctrl.sv
// ----------------------------------------------------------------------------
// scpe_ctrl
// Request sequencer: decides the flush, lookup, latch and invalidate steps
// of a request and drives the datapath through a command bus.
// ----------------------------------------------------------------------------
module scpe_ctrl
    import scpe_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  logic     i_wbe,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state, n_state;
    t_state r_ret, n_ret;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_PRE;
            end
            S_PRE: begin
                if (!i_wbe && i_stat.bvalid) begin
                    n_state = S_SCAN;
                    n_ret   = (i_stat.mode == MODE_FLUSH) ? S_IDLE : S_MAIN;
                end else begin
                    n_state = S_MAIN;
                end
            end
            S_MAIN: begin
                unique case (i_stat.mode)
                    MODE_READ: begin
                        if (i_wbe && i_stat.bvalid && i_stat.buf_eq_req) begin
                            n_state = S_RD_BUF;
                        end else begin
                            n_state = S_SCAN;
                            n_ret   = S_IDLE;
                        end
                    end
                    MODE_WRITE: begin
                        if (!i_wbe) begin
                            n_state = S_SCAN;
                            n_ret   = S_IDLE;
                        end else if (i_stat.bvalid && !i_stat.buf_eq_req) begin
                            n_state = S_SCAN;
                            n_ret   = S_LATCH;
                        end else begin
                            n_state = S_LATCH;
                        end
                    end
                    MODE_FLUSH: begin
                        if (i_stat.bvalid) begin
                            n_state = S_SCAN;
                            n_ret   = S_IDLE;
                        end else begin
                            n_state = S_NONE;
                        end
                    end
                    MODE_INVAL: n_state = S_NONE;
                    default:    n_state = S_NONE;
                endcase
            end
            S_SCAN: begin
                if (i_stat.scan_done) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free) n_state = r_ret;
            end
            S_RD_BUF, S_NONE, S_LATCH: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath commands
    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall     = 1'b0;
                o_cmd.load_req = i_in_valid;
            end
            S_PRE: begin
                // buffering switched off: push out the held sector first
                if (!i_wbe && i_stat.bvalid) begin
                    o_cmd.start_scan   = 1'b1;
                    o_cmd.key_buf      = 1'b1;
                    o_cmd.cmd_hit      = CMD_FLUSH_THROUGH;
                    o_cmd.cmd_miss     = CMD_FLUSH_THROUGH;
                    o_cmd.last         = (i_stat.mode == MODE_FLUSH);
                    o_cmd.clear_bvalid = 1'b1;
                end
            end
            S_MAIN: begin
                unique case (i_stat.mode)
                    MODE_READ: begin
                        if (!(i_wbe && i_stat.bvalid && i_stat.buf_eq_req)) begin
                            o_cmd.start_scan = 1'b1;
                            o_cmd.cmd_hit    = CMD_FROM_SLOT;
                            o_cmd.cmd_miss   = CMD_DEVICE_READ;
                            o_cmd.last       = 1'b1;
                        end
                    end
                    MODE_WRITE: begin
                        if (!i_wbe) begin
                            o_cmd.start_scan = 1'b1;
                            o_cmd.cmd_hit    = CMD_WRITE_THROUGH;
                            o_cmd.cmd_miss   = CMD_WRITE_THROUGH;
                            o_cmd.last       = 1'b1;
                        end else if (i_stat.bvalid && !i_stat.buf_eq_req) begin
                            // evict a different held sector before latching
                            o_cmd.start_scan   = 1'b1;
                            o_cmd.key_buf      = 1'b1;
                            o_cmd.cmd_hit      = CMD_FLUSH_THROUGH;
                            o_cmd.cmd_miss     = CMD_FLUSH_THROUGH;
                            o_cmd.clear_bvalid = 1'b1;
                        end
                    end
                    MODE_FLUSH: begin
                        if (i_stat.bvalid) begin
                            o_cmd.start_scan   = 1'b1;
                            o_cmd.key_buf      = 1'b1;
                            o_cmd.cmd_hit      = CMD_FLUSH_THROUGH;
                            o_cmd.cmd_miss     = CMD_FLUSH_THROUGH;
                            o_cmd.last         = 1'b1;
                            o_cmd.clear_bvalid = 1'b1;
                        end
                    end
                    MODE_INVAL: o_cmd.clear_tags = 1'b1;
                    default:    o_cmd.clear_tags = 1'b1;
                endcase
            end
            S_SCAN: o_cmd.scan_run = 1'b1;
            S_EMIT: o_cmd.emit_search = i_stat.out_free;
            S_RD_BUF: begin
                o_cmd.emit_direct = i_stat.out_free;
                o_cmd.direct_code = CMD_FROM_BUFFER;
            end
            S_NONE: begin
                o_cmd.emit_direct = i_stat.out_free;
                o_cmd.direct_code = CMD_NONE;
            end
            S_LATCH: begin
                o_cmd.emit_direct = i_stat.out_free;
                o_cmd.direct_code = CMD_LATCH;
                o_cmd.latch_buf   = i_stat.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

FILE: sv/scpe_dp.sv
// ----------------------------------------------------------------------------
// scpe_dp
// Datapath: request register, tag memory with valid bits, sequential tag
// scan, ring pointer, write buffer and the result register.
// ----------------------------------------------------------------------------
module scpe_dp
    import scpe_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_dp_cmd                i_cmd,
    output t_dp_stat               o_stat,
    input  logic [1:0]             i_mode,
    input  logic [SECTOR_W-1:0]    i_sector,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [2:0]             o_command,
    output logic [SLOT_PORT_W-1:0] o_slot,
    output logic [SECTOR_W-1:0]    o_device_sector,
    output logic                   o_was_hit,
    output logic                   o_last
);

    // Request and write buffer
    t_mode               r_mode;
    logic [SECTOR_W-1:0] r_req;
    logic                r_bvalid;
    logic [SECTOR_W-1:0] r_bsec;

    // Tag store
    logic [SECTOR_W-1:0] r_mem [CACHE_SLOTS];
    logic [CACHE_SLOTS-1:0] r_vld;
    logic [SLOT_W-1:0]   r_ring;

    // Scan
    logic [SECTOR_W-1:0] r_key;
    t_cmd_code           r_cmd_hit;
    t_cmd_code           r_cmd_miss;
    logic                r_last;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_pend;
    logic [SLOT_W-1:0]   r_cmp_idx;
    logic [SECTOR_W-1:0] r_rd_data;
    logic                r_rd_vld;
    logic                r_found;
    logic [SLOT_W-1:0]   r_hit_idx;

    // Result register
    logic                r_out_vld;
    t_cmd_code           r_out_cmd;
    logic [SLOT_W-1:0]   r_out_slot;
    logic [SECTOR_W-1:0] r_out_dev;
    logic                r_out_hit;
    logic                r_out_last;

    logic issue;
    logic match;
    logic out_free;
    logic fill;

    assign issue    = i_cmd.scan_run && (r_cnt != CNT_W'(CACHE_SLOTS));
    assign match    = r_pend && r_rd_vld && (r_rd_data == r_key)
                      && (r_key != EMPTY_TAG) && !r_found;
    assign out_free = !r_out_vld || !i_out_stall;
    assign fill     = i_cmd.emit_search && !r_found;

    // Request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_mode <= t_mode'(i_mode);
            r_req  <= i_sector;
        end
    end

    // Write buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bvalid <= 1'b0;
        end else if (i_cmd.latch_buf) begin
            r_bvalid <= 1'b1;
        end else if (i_cmd.clear_bvalid) begin
            r_bvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_buf) r_bsec <= r_req;
    end

    // Valid bits and ring pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_ring <= '0;
        end else if (i_cmd.clear_tags) begin
            r_vld  <= '0;
            r_ring <= '0;
        end else if (fill) begin
            r_vld[r_ring] <= 1'b1;
            r_ring <= (r_ring == SLOT_W'(CACHE_SLOTS - 1)) ? '0 : r_ring + 1'b1;
        end
    end

    // Tag memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (fill) r_mem[r_ring] <= r_key;
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd_data <= r_mem[r_cnt[SLOT_W-1:0]];
            r_rd_vld  <= r_vld[r_cnt[SLOT_W-1:0]];
            r_cmp_idx <= r_cnt[SLOT_W-1:0];
        end
    end

    // Search setup
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_scan) begin
            r_key      <= i_cmd.key_buf ? r_bsec : r_req;
            r_cmd_hit  <= i_cmd.cmd_hit;
            r_cmd_miss <= i_cmd.cmd_miss;
            r_last     <= i_cmd.last;
        end
    end

    // Scan sequencing, lowest match kept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_pend  <= 1'b0;
            r_found <= 1'b0;
        end else if (i_cmd.start_scan) begin
            r_cnt   <= '0;
            r_pend  <= 1'b0;
            r_found <= 1'b0;
        end else if (i_cmd.scan_run) begin
            r_pend <= issue;
            if (issue) r_cnt <= r_cnt + 1'b1;
            if (match) r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (match) r_hit_idx <= r_cmp_idx;
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.emit_search || i_cmd.emit_direct) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_search) begin
            r_out_cmd  <= r_found ? r_cmd_hit : r_cmd_miss;
            r_out_slot <= r_found ? r_hit_idx : r_ring;
            r_out_dev  <= r_key;
            r_out_hit  <= r_found;
            r_out_last <= r_last;
        end else if (i_cmd.emit_direct) begin
            r_out_cmd  <= i_cmd.direct_code;
            r_out_slot <= '0;
            r_out_dev  <= (i_cmd.direct_code == CMD_NONE) ? '0 : r_req;
            r_out_hit  <= 1'b0;
            r_out_last <= 1'b1;
        end
    end

    // Status
    assign o_stat.mode       = r_mode;
    assign o_stat.bvalid     = r_bvalid;
    assign o_stat.buf_eq_req = (r_bsec == r_req);
    assign o_stat.scan_done  = (r_cnt == CNT_W'(CACHE_SLOTS)) && !r_pend;
    assign o_stat.out_free   = out_free;

    // Ports
    assign o_out_valid     = r_out_vld;
    assign o_command       = r_out_cmd;
    assign o_slot          = SLOT_PORT_W'(r_out_slot);
    assign o_device_sector = r_out_dev;
    assign o_was_hit       = r_out_hit;
    assign o_last          = r_out_last;

    // Checks
    a_ring_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_ring} < CNT_W'(CACHE_SLOTS)))
        else $error("ring pointer out of range");

    a_clear_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear_tags |=> (r_vld == '0) && (r_ring == '0))
        else $error("invalidate did not clear the tags");

    a_fill_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fill |=> r_vld[$past(r_ring)])
        else $error("filled slot not marked valid");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit_search || i_cmd.emit_direct) |-> out_free)
        else $error("result register overwritten");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_out_cmd == CMD_NONE))
            |-> (r_out_dev == '0) && (r_out_slot == '0) && !r_out_hit)
        else $error("empty command carries data");

endmodule

FILE: sv/sector_cache_policy_engine_top.sv
// ----------------------------------------------------------------------------
// sector_cache_policy_engine_top
// Tag and replacement policy engine of a sector cache with a one-sector
// write-back buffer; emits data-movement commands per request.
// ----------------------------------------------------------------------------
// Usage:
//   Requests (mode, sector) enter on the input channel; a transfer happens
//   when i_in_valid is high and o_in_stall is low. One request is worked on
//   at a time; o_in_stall stays high until its last result is loaded.
//   Each request yields one or two results on the output channel, the final
//   one flagged by o_last. A transfer happens when o_out_valid is high and
//   i_out_stall is low; a stalled result holds in the output register and the
//   engine waits for it.
//   A lookup scans all slots through the single tag memory read port, one
//   slot per cycle; a request with a flush and a lookup runs two scans.
//   write_back_enable lies at APB byte addresses 0 to 3; pready is always high.
//   Reset empties all tags at once (per-slot valid bits), sets the ring
//   pointer to 0, empties the write buffer and clears write_back_enable.
// ----------------------------------------------------------------------------
module sector_cache_policy_engine_top
    import scpe_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // request channel
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [1:0]             i_mode,
    input  logic [SECTOR_W-1:0]    i_sector,
    // result channel
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [2:0]             o_command,
    output logic [SLOT_PORT_W-1:0] o_slot,
    output logic [SECTOR_W-1:0]    o_device_sector,
    output logic                   o_was_hit,
    output logic                   o_last,
    // configuration
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_AW-1:0]      paddr,
    input  logic [APB_DW-1:0]      pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready
);

    logic     r_wbe;
    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;
    logic     reg0_sel;

    // Configuration register
    assign reg0_sel = (paddr[APB_AW-1] == 1'b0);
    assign pready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wbe <= 1'b0;
        end else if (psel && penable && pwrite && reg0_sel) begin
            r_wbe <= pwdata[0];
        end
    end

    assign prdata = reg0_sel ? {{(APB_DW-1){1'b0}}, r_wbe} : '0;

    // Sequencer
    scpe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_wbe      (r_wbe),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    // Tag store and result path
    scpe_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_stat          (dp_stat),
        .i_mode          (i_mode),
        .i_sector        (i_sector),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_command       (o_command),
        .o_slot          (o_slot),
        .o_device_sector (o_device_sector),
        .o_was_hit       (o_was_hit),
        .o_last          (o_last)
    );

endmodule
